FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Implication checks on a clock with a synchronous reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CCR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define CCR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define CCR_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define CCR_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/ccr_pkg.sv
// ---------------------------------------------------------------------------
// Catmull-Rom interpolator package
// Widths, limits, sequencer opcodes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package ccr_pkg;

   localparam int COORD_WIDTH = 24;
   localparam int SEG_W       = 6;
   localparam logic [SEG_W-1:0] SEG_RESET = 6'd8;
   localparam int DATA_W      = ((2 * COORD_WIDTH + 7) / 8) * 8;

   localparam int MAG_W  = 32;
   localparam int KNOT_W = 32;
   localparam int T_W    = KNOT_W + 2;
   localparam int NUM_W  = T_W + 1;
   localparam int W_W    = 28;
   localparam int P_W    = 36;
   localparam int ACC_W  = 64;
   localparam int DVD_W  = 64;
   localparam int SQ_W   = 64;
   localparam int ROOT_W = 32;

   localparam logic [63:0] DIFF_LIM   = 64'd3037000499;
   localparam logic [63:0] WEIGHT_LIM = 64'd134217727;
   localparam logic signed [ACC_W-1:0] INTER_LIM = 64'sd17179869183;

   localparam logic [2:0] LV_A1  = 3'd0;
   localparam logic [2:0] LV_A2  = 3'd1;
   localparam logic [2:0] LV_A3  = 3'd2;
   localparam logic [2:0] LV_B1  = 3'd3;
   localparam logic [2:0] LV_B2  = 3'd4;
   localparam logic [2:0] LV_OUT = 3'd5;

   typedef enum logic [4:0] {
      OP_NOP,
      OP_LOAD,
      OP_DIFF,
      OP_SQX,
      OP_SQY,
      OP_RT1,
      OP_RT1_TAKE,
      OP_RT2,
      OP_RT2_TAKE,
      OP_SHIFT,
      OP_SEGPREP,
      OP_TMUL,
      OP_TDIV,
      OP_TTAKE,
      OP_WDIV,
      OP_WTAKE,
      OP_MAC,
      OP_BEND,
      OP_EMIT_SAMPLE,
      OP_EMIT_DEGEN,
      OP_EMIT_END,
      OP_CLEAR
   } ccr_op_type;

   typedef struct packed {
      ccr_op_type       op;
      logic [2:0]       lv;
      logic             sel;
      logic [1:0]       ph;
      logic             axis;
      logic             use_knot;
      logic             last;
      logic [SEG_W-1:0] j;
      logic [SEG_W-1:0] n;
   } ccr_cmd_type;

   typedef struct packed {
      logic sqrt_busy;
      logic div_busy;
      logic out_free;
      logic zero_knot;
   } ccr_status_type;

endpackage

FILE: hw/rtl/ccr_isqrt.sv
// ---------------------------------------------------------------------------
// Iterative integer square root
// Floor square root, two argument bits per cycle.
// ---------------------------------------------------------------------------
module ccr_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ccr_pkg::SQ_W-1:0]      arg,
   output logic                          busy,
   output logic [ccr_pkg::ROOT_W-1:0]    root
);

   localparam int STEPS = ccr_pkg::ROOT_W;
   localparam int CNT_W = $clog2(STEPS);

   logic                        busy_ff, busy_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [ccr_pkg::SQ_W-1:0]    arg_ff, arg_in;
   logic [ccr_pkg::ROOT_W-1:0]  root_ff, root_in;
   logic [ccr_pkg::ROOT_W+2:0]  rem_ff, rem_in;
   logic [ccr_pkg::ROOT_W+2:0]  rem2, trial;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      arg_in  = arg_ff;
      root_in = root_ff;
      rem_in  = rem_ff;
      rem2    = {rem_ff[ccr_pkg::ROOT_W:0], arg_ff[ccr_pkg::SQ_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         arg_in  = arg;
         root_in = '0;
         rem_in  = '0;
      end else if (busy_ff) begin
         arg_in = {arg_ff[ccr_pkg::SQ_W-3:0], 2'b00};
         if (rem2 >= trial) begin
            rem_in  = rem2 - trial;
            root_in = {root_ff[ccr_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem2;
            root_in = {root_ff[ccr_pkg::ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      arg_ff  <= arg_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

FILE: hw/rtl/ccr_divider.sv
// ---------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module ccr_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ccr_pkg::DVD_W-1:0]   dividend,
   input  logic [ccr_pkg::T_W-1:0]     divisor,
   output logic                        busy,
   output logic [ccr_pkg::DVD_W-1:0]   quotient
);

   localparam int STEPS = ccr_pkg::DVD_W;
   localparam int CNT_W = $clog2(STEPS);

   logic                       busy_ff, busy_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [ccr_pkg::DVD_W-1:0]  dvd_ff, dvd_in;
   logic [ccr_pkg::T_W-1:0]    dvs_ff, dvs_in;
   logic [ccr_pkg::T_W-1:0]    rem_ff, rem_in;
   logic [ccr_pkg::T_W:0]      rem2;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      rem2    = {rem_ff, dvd_ff[ccr_pkg::DVD_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (rem2 >= {1'b0, dvs_ff}) begin
            rem_in = ccr_pkg::T_W'(rem2 - {1'b0, dvs_ff});
            dvd_in = {dvd_ff[ccr_pkg::DVD_W-2:0], 1'b1};
         end else begin
            rem_in = rem2[ccr_pkg::T_W-1:0];
            dvd_in = {dvd_ff[ccr_pkg::DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign busy     = busy_ff;
   assign quotient = dvd_ff;

endmodule

FILE: hw/rtl/ccr_datapath.sv
// ---------------------------------------------------------------------------
// Catmull-Rom datapath
// Point window, knots, weights, blend accumulator and result register.
// ---------------------------------------------------------------------------
module ccr_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ccr_pkg::ccr_cmd_type                 cmd,
   output ccr_pkg::ccr_status_type              status,
   input  logic signed [ccr_pkg::COORD_WIDTH-1:0] in_x,
   input  logic signed [ccr_pkg::COORD_WIDTH-1:0] in_y,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic signed [ccr_pkg::COORD_WIDTH-1:0] res_x,
   output logic signed [ccr_pkg::COORD_WIDTH-1:0] res_y,
   output logic                                 res_last,
   output logic                                 res_cend,
   output logic                                 res_degen
);

   localparam int CW = ccr_pkg::COORD_WIDTH;
   localparam logic signed [ccr_pkg::P_W-1:0] CMAX =
      ccr_pkg::P_W'((64'sd1 <<< (CW - 1)) - 64'sd1);
   localparam logic signed [ccr_pkg::P_W-1:0] CMIN = -CMAX - 1;

   function automatic logic signed [CW-1:0] sat_coord(input logic signed [ccr_pkg::P_W-1:0] v);
      logic signed [ccr_pkg::P_W-1:0] c;
      c = (v > CMAX) ? CMAX : ((v < CMIN) ? CMIN : v);
      return c[CW-1:0];
   endfunction

   logic signed [CW-1:0] in_x_ff, in_y_ff;
   logic signed [CW-1:0] win_x_ff [4];
   logic signed [CW-1:0] win_y_ff [4];
   logic [ccr_pkg::KNOT_W-1:0] knot_ff [3];
   logic [ccr_pkg::MAG_W-1:0]  mx_ff, my_ff;
   logic [ccr_pkg::SQ_W-1:0]   sq_ff;
   logic [ccr_pkg::ROOT_W-1:0] len_ff, kn_ff;
   logic [ccr_pkg::T_W-1:0]    t1_ff, t2_ff, t3_ff, t31_ff, t_ff;
   logic [ccr_pkg::DVD_W-1:0]  prod_ff;
   logic                       wneg_ff;
   logic signed [ccr_pkg::W_W-1:0] wa_ff, wb_ff, w2_ff, w3_ff;
   logic signed [ccr_pkg::ACC_W-1:0] acc_ff;
   logic signed [ccr_pkg::P_W-1:0] a1x_ff, a2x_ff, a3x_ff, b1x_ff, b2x_ff, rx_ff;
   logic signed [ccr_pkg::P_W-1:0] a1y_ff, a2y_ff, a3y_ff, b1y_ff, b2y_ff, ry_ff;
   logic                       out_valid_ff;
   logic signed [CW-1:0]       out_x_ff, out_y_ff;
   logic                       out_last_ff, out_cend_ff, out_degen_ff;

   logic signed [CW:0]          dx, dy;
   logic [CW:0]                 dxm, dym;
   logic [ccr_pkg::MAG_W-1:0]   mx_c, my_c;
   logic [ccr_pkg::SQ_W-1:0]    sqp;
   logic                        sqrt_start, sqrt_busy, div_start, div_busy;
   logic [ccr_pkg::SQ_W-1:0]    sqrt_arg;
   logic [ccr_pkg::ROOT_W-1:0]  sqrt_root;
   logic [ccr_pkg::DVD_W-1:0]   div_dvd, div_q;
   logic [ccr_pkg::T_W-1:0]     div_dvs;
   logic signed [ccr_pkg::NUM_W-1:0] ts, t1s, t2s, t3s, num;
   logic [ccr_pkg::T_W-1:0]     den;
   logic [ccr_pkg::NUM_W-1:0]   num_mag;
   logic [3:0]                  widx;
   logic [ccr_pkg::W_W-1:0]     wmag;
   logic signed [ccr_pkg::W_W-1:0] wval;
   logic signed [ccr_pkg::P_W-1:0] op_p, op_q, op_m;
   logic signed [ccr_pkg::W_W-1:0] op_wp, op_wq, op_w;
   logic signed [14:0]          wpart;
   logic signed [ccr_pkg::ACC_W-1:0] part, shr;
   logic signed [ccr_pkg::P_W-1:0] bres;
   logic                        out_free;

   assign dx   = (CW+1)'(in_x_ff) - (CW+1)'(win_x_ff[3]);
   assign dy   = (CW+1)'(in_y_ff) - (CW+1)'(win_y_ff[3]);
   assign dxm  = dx[CW] ? (CW+1)'(-dx) : dx;
   assign dym  = dy[CW] ? (CW+1)'(-dy) : dy;
   assign mx_c = (64'(dxm) > ccr_pkg::DIFF_LIM) ? ccr_pkg::DIFF_LIM[ccr_pkg::MAG_W-1:0]
                                                : ccr_pkg::MAG_W'(dxm);
   assign my_c = (64'(dym) > ccr_pkg::DIFF_LIM) ? ccr_pkg::DIFF_LIM[ccr_pkg::MAG_W-1:0]
                                                : ccr_pkg::MAG_W'(dym);

   always_comb begin
      if (cmd.op == ccr_pkg::OP_SQX) begin
         sqp = ccr_pkg::SQ_W'(mx_ff) * ccr_pkg::SQ_W'(mx_ff);
      end else begin
         sqp = ccr_pkg::SQ_W'(my_ff) * ccr_pkg::SQ_W'(my_ff);
      end
   end

   assign sqrt_start = (cmd.op == ccr_pkg::OP_RT1) || (cmd.op == ccr_pkg::OP_RT2);
   assign sqrt_arg   = (cmd.op == ccr_pkg::OP_RT1) ? sq_ff
                                                   : (ccr_pkg::SQ_W'(len_ff) << 24);

   ccr_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .arg   (sqrt_arg),
      .busy  (sqrt_busy),
      .root  (sqrt_root)
   );

   assign ts  = $signed({1'b0, t_ff});
   assign t1s = $signed({1'b0, t1_ff});
   assign t2s = $signed({1'b0, t2_ff});
   assign t3s = $signed({1'b0, t3_ff});
   assign widx = {cmd.lv, cmd.sel};

   always_comb begin
      case (widx)
         4'd0:    begin num = t1s - ts; den = ccr_pkg::T_W'(knot_ff[0]); end
         4'd1:    begin num = ts;       den = ccr_pkg::T_W'(knot_ff[0]); end
         4'd2:    begin num = t2s - ts; den = ccr_pkg::T_W'(knot_ff[1]); end
         4'd3:    begin num = ts - t1s; den = ccr_pkg::T_W'(knot_ff[1]); end
         4'd4:    begin num = t3s - ts; den = ccr_pkg::T_W'(knot_ff[2]); end
         4'd5:    begin num = ts - t2s; den = ccr_pkg::T_W'(knot_ff[2]); end
         4'd6:    begin num = t2s - ts; den = t2_ff; end
         4'd7:    begin num = ts;       den = t2_ff; end
         4'd8:    begin num = t3s - ts; den = t31_ff; end
         4'd9:    begin num = ts - t1s; den = t31_ff; end
         default: begin num = '0;       den = '1; end
      endcase
   end

   assign num_mag   = num[ccr_pkg::NUM_W-1] ? ccr_pkg::NUM_W'(-num) : ccr_pkg::NUM_W'(num);
   assign div_start = (cmd.op == ccr_pkg::OP_TDIV) || (cmd.op == ccr_pkg::OP_WDIV);
   assign div_dvd   = (cmd.op == ccr_pkg::OP_TDIV) ? prod_ff
                                                   : (ccr_pkg::DVD_W'(num_mag) << 16);
   assign div_dvs   = (cmd.op == ccr_pkg::OP_TDIV) ? ccr_pkg::T_W'(cmd.n) : den;

   ccr_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .busy     (div_busy),
      .quotient (div_q)
   );

   assign wmag = (div_q > ccr_pkg::WEIGHT_LIM) ? ccr_pkg::WEIGHT_LIM[ccr_pkg::W_W-1:0]
                                               : div_q[ccr_pkg::W_W-1:0];
   assign wval = wneg_ff ? -$signed(wmag) : $signed(wmag);

   always_comb begin
      op_wp = wa_ff;
      op_wq = wb_ff;
      unique case (cmd.lv)
         ccr_pkg::LV_A1: begin
            op_p = cmd.axis ? ccr_pkg::P_W'(win_y_ff[0]) : ccr_pkg::P_W'(win_x_ff[0]);
            op_q = cmd.axis ? ccr_pkg::P_W'(win_y_ff[1]) : ccr_pkg::P_W'(win_x_ff[1]);
         end
         ccr_pkg::LV_A2: begin
            op_p = cmd.axis ? ccr_pkg::P_W'(win_y_ff[1]) : ccr_pkg::P_W'(win_x_ff[1]);
            op_q = cmd.axis ? ccr_pkg::P_W'(win_y_ff[2]) : ccr_pkg::P_W'(win_x_ff[2]);
         end
         ccr_pkg::LV_A3: begin
            op_p = cmd.axis ? ccr_pkg::P_W'(win_y_ff[2]) : ccr_pkg::P_W'(win_x_ff[2]);
            op_q = cmd.axis ? ccr_pkg::P_W'(win_y_ff[3]) : ccr_pkg::P_W'(win_x_ff[3]);
         end
         ccr_pkg::LV_B1: begin
            op_p = cmd.axis ? a1y_ff : a1x_ff;
            op_q = cmd.axis ? a2y_ff : a2x_ff;
         end
         ccr_pkg::LV_B2: begin
            op_p = cmd.axis ? a2y_ff : a2x_ff;
            op_q = cmd.axis ? a3y_ff : a3x_ff;
         end
         default: begin
            op_p  = cmd.axis ? b1y_ff : b1x_ff;
            op_q  = cmd.axis ? b2y_ff : b2x_ff;
            op_wp = w2_ff;
            op_wq = w3_ff;
         end
      endcase
      op_m  = cmd.ph[1] ? op_q : op_p;
      op_w  = cmd.ph[1] ? op_wq : op_wp;
      wpart = cmd.ph[0] ? 15'($signed(op_w[ccr_pkg::W_W-1:14]))
                        : $signed({1'b0, op_w[13:0]});
      part  = ccr_pkg::ACC_W'(op_m) * ccr_pkg::ACC_W'(wpart);
      if (cmd.ph[0]) begin
         part = part <<< 14;
      end
   end

   assign shr  = acc_ff >>> 16;
   assign bres = (shr > ccr_pkg::INTER_LIM)  ? ccr_pkg::P_W'(ccr_pkg::INTER_LIM)
               : (shr < -ccr_pkg::INTER_LIM) ? ccr_pkg::P_W'(-ccr_pkg::INTER_LIM)
               : ccr_pkg::P_W'(shr);

   assign out_free = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            win_x_ff[i] <= '0;
            win_y_ff[i] <= '0;
         end
         for (int i = 0; i < 3; i++) begin
            knot_ff[i] <= '0;
         end
      end else begin
         if ((cmd.op == ccr_pkg::OP_EMIT_SAMPLE) || (cmd.op == ccr_pkg::OP_EMIT_DEGEN) ||
             (cmd.op == ccr_pkg::OP_EMIT_END)) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (cmd.op == ccr_pkg::OP_SHIFT) begin
            for (int i = 0; i < 3; i++) begin
               win_x_ff[i] <= win_x_ff[i+1];
               win_y_ff[i] <= win_y_ff[i+1];
            end
            win_x_ff[3] <= in_x_ff;
            win_y_ff[3] <= in_y_ff;
            knot_ff[0]  <= knot_ff[1];
            knot_ff[1]  <= knot_ff[2];
            knot_ff[2]  <= cmd.use_knot ? ccr_pkg::KNOT_W'(kn_ff) : '0;
         end else if (cmd.op == ccr_pkg::OP_CLEAR) begin
            for (int i = 0; i < 4; i++) begin
               win_x_ff[i] <= '0;
               win_y_ff[i] <= '0;
            end
            for (int i = 0; i < 3; i++) begin
               knot_ff[i] <= '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         ccr_pkg::OP_LOAD: begin
            in_x_ff <= in_x;
            in_y_ff <= in_y;
         end
         ccr_pkg::OP_DIFF: begin
            mx_ff <= mx_c;
            my_ff <= my_c;
         end
         ccr_pkg::OP_SQX:      sq_ff  <= sqp;
         ccr_pkg::OP_SQY:      sq_ff  <= sq_ff + sqp;
         ccr_pkg::OP_RT1_TAKE: len_ff <= sqrt_root;
         ccr_pkg::OP_RT2_TAKE: kn_ff  <= sqrt_root;
         ccr_pkg::OP_SEGPREP: begin
            t1_ff  <= ccr_pkg::T_W'(knot_ff[0]);
            t2_ff  <= ccr_pkg::T_W'(knot_ff[0]) + ccr_pkg::T_W'(knot_ff[1]);
            t3_ff  <= ccr_pkg::T_W'(knot_ff[0]) + ccr_pkg::T_W'(knot_ff[1])
                    + ccr_pkg::T_W'(knot_ff[2]);
            t31_ff <= ccr_pkg::T_W'(knot_ff[1]) + ccr_pkg::T_W'(knot_ff[2]);
         end
         ccr_pkg::OP_TMUL:  prod_ff <= ccr_pkg::DVD_W'(cmd.j) * ccr_pkg::DVD_W'(knot_ff[1]);
         ccr_pkg::OP_TTAKE: t_ff    <= t1_ff + div_q[ccr_pkg::T_W-1:0];
         ccr_pkg::OP_WDIV:  wneg_ff <= num[ccr_pkg::NUM_W-1];
         ccr_pkg::OP_WTAKE: begin
            if (cmd.sel) begin
               wb_ff <= wval;
               if (cmd.lv == ccr_pkg::LV_A2) begin
                  w3_ff <= wval;
               end
            end else begin
               wa_ff <= wval;
               if (cmd.lv == ccr_pkg::LV_A2) begin
                  w2_ff <= wval;
               end
            end
         end
         ccr_pkg::OP_MAC: begin
            acc_ff <= ((cmd.ph == 2'd0) ? ccr_pkg::ACC_W'(32768) : acc_ff) + part;
         end
         ccr_pkg::OP_BEND: begin
            unique case (cmd.lv)
               ccr_pkg::LV_A1: if (cmd.axis) a1y_ff <= bres; else a1x_ff <= bres;
               ccr_pkg::LV_A2: if (cmd.axis) a2y_ff <= bres; else a2x_ff <= bres;
               ccr_pkg::LV_A3: if (cmd.axis) a3y_ff <= bres; else a3x_ff <= bres;
               ccr_pkg::LV_B1: if (cmd.axis) b1y_ff <= bres; else b1x_ff <= bres;
               ccr_pkg::LV_B2: if (cmd.axis) b2y_ff <= bres; else b2x_ff <= bres;
               default:        if (cmd.axis) ry_ff  <= bres; else rx_ff  <= bres;
            endcase
         end
         ccr_pkg::OP_EMIT_SAMPLE: begin
            out_x_ff     <= sat_coord(rx_ff);
            out_y_ff     <= sat_coord(ry_ff);
            out_last_ff  <= cmd.last;
            out_cend_ff  <= 1'b0;
            out_degen_ff <= 1'b0;
         end
         ccr_pkg::OP_EMIT_DEGEN: begin
            out_x_ff     <= win_x_ff[1];
            out_y_ff     <= win_y_ff[1];
            out_last_ff  <= cmd.last;
            out_cend_ff  <= 1'b0;
            out_degen_ff <= 1'b1;
         end
         ccr_pkg::OP_EMIT_END: begin
            out_x_ff     <= in_x_ff;
            out_y_ff     <= in_y_ff;
            out_last_ff  <= 1'b1;
            out_cend_ff  <= 1'b1;
            out_degen_ff <= 1'b0;
         end
         default: begin
         end
      endcase
   end

   assign status.sqrt_busy = sqrt_busy;
   assign status.div_busy  = div_busy;
   assign status.out_free  = out_free;
   assign status.zero_knot = (knot_ff[0] == '0) || (knot_ff[1] == '0) || (knot_ff[2] == '0);

   assign rsp_valid = out_valid_ff;
   assign res_x     = out_x_ff;
   assign res_y     = out_y_ff;
   assign res_last  = out_last_ff;
   assign res_cend  = out_cend_ff;
   assign res_degen = out_degen_ff;

endmodule

FILE: hw/rtl/ccr_controller.sv
// ---------------------------------------------------------------------------
// Catmull-Rom sequencer
// Steps the datapath through knot, weight, blend and emit operations.
// ---------------------------------------------------------------------------
module ccr_controller (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_final,
   output logic                          req_ready,
   input  logic                          csr_wr_en,
   input  logic [ccr_pkg::SEG_W-1:0]     csr_wr_data,
   input  ccr_pkg::ccr_status_type       status,
   output ccr_pkg::ccr_cmd_type          cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_DIFF, S_SQX, S_SQY, S_RT1, S_RT1W, S_RT2, S_RT2W, S_SHIFT,
      S_SEG, S_DEGEN, S_TMUL, S_TDIV, S_TDIVW, S_WDIV, S_WDIVW, S_MAC,
      S_BEND, S_EMIT, S_END, S_FINISH
   } state_type;

   state_type                 state_ff;
   logic [1:0]                pts_ff, before_ff;
   logic                      fin_ff, sel_ff, axis_ff;
   logic [ccr_pkg::SEG_W-1:0] seg_n_ff, n_ff, j_ff;
   logic [2:0]                lv_ff;
   logic [1:0]                ph_ff;
   logic                      end_pt, last_j;

   assign end_pt    = fin_ff && (before_ff != 2'd0);
   assign last_j    = (j_ff == n_ff - 1'b1);
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd          = '0;
      cmd.op       = ccr_pkg::OP_NOP;
      cmd.lv       = lv_ff;
      cmd.sel      = sel_ff;
      cmd.ph       = ph_ff;
      cmd.axis     = axis_ff;
      cmd.use_knot = (before_ff != 2'd0);
      cmd.last     = last_j && !end_pt;
      cmd.j        = j_ff;
      cmd.n        = n_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid) cmd.op = ccr_pkg::OP_LOAD;
         S_DIFF:   cmd.op = ccr_pkg::OP_DIFF;
         S_SQX:    cmd.op = ccr_pkg::OP_SQX;
         S_SQY:    cmd.op = ccr_pkg::OP_SQY;
         S_RT1:    cmd.op = ccr_pkg::OP_RT1;
         S_RT1W:   if (!status.sqrt_busy) cmd.op = ccr_pkg::OP_RT1_TAKE;
         S_RT2:    cmd.op = ccr_pkg::OP_RT2;
         S_RT2W:   if (!status.sqrt_busy) cmd.op = ccr_pkg::OP_RT2_TAKE;
         S_SHIFT:  cmd.op = ccr_pkg::OP_SHIFT;
         S_SEG:    cmd.op = ccr_pkg::OP_SEGPREP;
         S_DEGEN:  if (status.out_free) cmd.op = ccr_pkg::OP_EMIT_DEGEN;
         S_TMUL:   cmd.op = ccr_pkg::OP_TMUL;
         S_TDIV:   cmd.op = ccr_pkg::OP_TDIV;
         S_TDIVW:  if (!status.div_busy) cmd.op = ccr_pkg::OP_TTAKE;
         S_WDIV:   cmd.op = ccr_pkg::OP_WDIV;
         S_WDIVW:  if (!status.div_busy) cmd.op = ccr_pkg::OP_WTAKE;
         S_MAC:    cmd.op = ccr_pkg::OP_MAC;
         S_BEND:   cmd.op = ccr_pkg::OP_BEND;
         S_EMIT:   if (status.out_free) cmd.op = ccr_pkg::OP_EMIT_SAMPLE;
         S_END:    if (status.out_free) cmd.op = ccr_pkg::OP_EMIT_END;
         S_FINISH: if (fin_ff) cmd.op = ccr_pkg::OP_CLEAR;
         default:  cmd.op = ccr_pkg::OP_NOP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         pts_ff    <= '0;
         before_ff <= '0;
         fin_ff    <= 1'b0;
         seg_n_ff  <= ccr_pkg::SEG_RESET;
         n_ff      <= '0;
         j_ff      <= '0;
         lv_ff     <= '0;
         sel_ff    <= 1'b0;
         ph_ff     <= '0;
         axis_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            seg_n_ff <= csr_wr_data;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  before_ff <= pts_ff;
                  fin_ff    <= req_final;
                  n_ff      <= seg_n_ff;
                  state_ff  <= (pts_ff != 2'd0) ? S_DIFF : S_SHIFT;
               end
            end
            S_DIFF: state_ff <= S_SQX;
            S_SQX:  state_ff <= S_SQY;
            S_SQY:  state_ff <= S_RT1;
            S_RT1:  state_ff <= S_RT1W;
            S_RT1W: if (!status.sqrt_busy) state_ff <= S_RT2;
            S_RT2:  state_ff <= S_RT2W;
            S_RT2W: if (!status.sqrt_busy) state_ff <= S_SHIFT;
            S_SHIFT: begin
               if (pts_ff != 2'd3) begin
                  pts_ff <= pts_ff + 1'b1;
               end
               if (n_ff == '0) begin
                  state_ff <= S_FINISH;
               end else if (before_ff == 2'd3) begin
                  state_ff <= S_SEG;
               end else if (end_pt) begin
                  state_ff <= S_END;
               end else begin
                  state_ff <= S_FINISH;
               end
            end
            S_SEG: begin
               j_ff     <= '0;
               state_ff <= status.zero_knot ? S_DEGEN : S_TMUL;
            end
            S_DEGEN: begin
               if (status.out_free) begin
                  j_ff <= j_ff + 1'b1;
                  if (last_j) begin
                     state_ff <= end_pt ? S_END : S_FINISH;
                  end
               end
            end
            S_TMUL: state_ff <= S_TDIV;
            S_TDIV: state_ff <= S_TDIVW;
            S_TDIVW: begin
               if (!status.div_busy) begin
                  lv_ff    <= ccr_pkg::LV_A1;
                  sel_ff   <= 1'b0;
                  state_ff <= S_WDIV;
               end
            end
            S_WDIV: state_ff <= S_WDIVW;
            S_WDIVW: begin
               if (!status.div_busy) begin
                  if (!sel_ff) begin
                     sel_ff   <= 1'b1;
                     state_ff <= S_WDIV;
                  end else begin
                     sel_ff   <= 1'b0;
                     ph_ff    <= '0;
                     axis_ff  <= 1'b0;
                     state_ff <= S_MAC;
                  end
               end
            end
            S_MAC: begin
               ph_ff <= ph_ff + 1'b1;
               if (ph_ff == 2'd3) begin
                  state_ff <= S_BEND;
               end
            end
            S_BEND: begin
               ph_ff <= '0;
               if (!axis_ff) begin
                  axis_ff  <= 1'b1;
                  state_ff <= S_MAC;
               end else begin
                  axis_ff <= 1'b0;
                  if (lv_ff == ccr_pkg::LV_OUT) begin
                     state_ff <= S_EMIT;
                  end else begin
                     lv_ff    <= lv_ff + 1'b1;
                     state_ff <= (lv_ff == ccr_pkg::LV_B2) ? S_MAC : S_WDIV;
                  end
               end
            end
            S_EMIT: begin
               if (status.out_free) begin
                  j_ff <= j_ff + 1'b1;
                  if (last_j) begin
                     state_ff <= end_pt ? S_END : S_FINISH;
                  end else begin
                     state_ff <= S_TMUL;
                  end
               end
            end
            S_END: if (status.out_free) state_ff <= S_FINISH;
            S_FINISH: begin
               if (fin_ff) begin
                  pts_ff <= '0;
               end
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

FILE: hw/rtl/centripetal_catmull_rom_interpolator_top.sv
// ---------------------------------------------------------------------------
// Centripetal Catmull-Rom interpolator
// Streams 2-D control points in and interpolated curve samples out.
// ---------------------------------------------------------------------------
// Input items carry one control point; req_tlast marks the trailing end point
// of a curve. From the fourth point of a curve on, each item yields
// segment_points samples; the marked point also yields itself as curve end
// once a point precedes it and segment_points is nonzero. rsp_tlast flags
// the last item caused by one input item. segment_points is written through
// csr_wr_en/csr_wr_data; the user must write it only while idle, as the
// block itself does not enforce this. One item is worked at a time;
// req_tready is high only when idle. Each item is loaded, its knot is found
// with two 32-step square roots once a point precedes it, and the window is
// shifted. Each segment sample runs eleven 64-step divisions on the shared
// radix-2 divider, with blend multiply-accumulate. A degenerate segment emits
// one sample per cycle while the output register is free. Reset clears the
// point window, the knots and the point count, and sets segment_points to 8.
// When the receiver stalls, the result is held in the output register and
// the sequencer waits before the next emit.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module centripetal_catmull_rom_interpolator_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [ccr_pkg::DATA_W-1:0]    req_tdata,   // point_x, point_y
   input  logic                          req_tlast,   // is_final
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [ccr_pkg::DATA_W-1:0]    rsp_tdata,   // out_x, out_y
   output logic                          rsp_tlast,   // run_end
   output logic [1:0]                    rsp_tuser,   // curve_end, degenerate
   input  logic                          csr_wr_en,
   input  logic [ccr_pkg::SEG_W-1:0]     csr_wr_data
);

   localparam int CW = ccr_pkg::COORD_WIDTH;

   ccr_pkg::ccr_cmd_type    cmd;
   ccr_pkg::ccr_status_type status;
   logic signed [CW-1:0]    res_x, res_y;
   logic                    res_last, res_cend, res_degen;

   ccr_controller u_controller (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_final   (req_tlast),
      .req_ready   (req_tready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .status      (status),
      .cmd         (cmd)
   );

   ccr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .in_x      (req_tdata[CW-1:0]),
      .in_y      (req_tdata[2*CW-1:CW]),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .res_x     (res_x),
      .res_y     (res_y),
      .res_last  (res_last),
      .res_cend  (res_cend),
      .res_degen (res_degen)
   );

   assign rsp_tdata = ccr_pkg::DATA_W'({res_y, res_x});
   assign rsp_tlast = res_last;
   assign rsp_tuser = {res_degen, res_cend};

   `CCR_ASSERT_IMP(a_idle_units, clock, reset, req_tready, !status.div_busy && !status.sqrt_busy)
   `CCR_ASSERT_NXT(a_one_item, clock, reset, req_tvalid && req_tready, !req_tready)
   `CCR_ASSERT_IMP(a_end_last, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tlast)
   `CCR_ASSERT_IMP(a_end_clean, clock, reset, rsp_tvalid && rsp_tuser[0], !rsp_tuser[1])

endmodule

FILE: verif/tb_centripetal_catmull_rom_interpolator_top.sv
// ---------------------------------------------------------------------------
// Catmull-Rom interpolator testbench
// Streams control-point curves into the block and checks every sample
// against a fixed-point spline predictor, under random idling, long
// receiver hold-off and several segment_points settings.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_centripetal_catmull_rom_interpolator_top;

   localparam int CW = ccr_pkg::COORD_WIDTH;
   localparam longint WLIM = 64'sd134217727;
   localparam longint ILIM = 64'sd17179869183;
   localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
   localparam longint CMIN = -(64'sd1 <<< (CW - 1));

   typedef struct {
      logic [CW-1:0] x;
      logic [CW-1:0] y;
      bit            fin;
   } point_type;

   typedef struct {
      logic [CW-1:0] x;
      logic [CW-1:0] y;
      bit            run_end;
      bit            curve_end;
      bit            degen;
   } sample_type;

   logic                        clock;
   logic                        reset;
   logic                        req_tvalid;
   logic                        req_tready;
   logic [ccr_pkg::DATA_W-1:0]  req_tdata;
   logic                        req_tlast;
   logic                        rsp_tvalid;
   logic                        rsp_tready;
   logic [ccr_pkg::DATA_W-1:0]  rsp_tdata;
   logic                        rsp_tlast;
   logic [1:0]                  rsp_tuser;
   logic                        csr_wr_en;
   logic [ccr_pkg::SEG_W-1:0]   csr_wr_data;

   point_type  point_q[$];
   sample_type sample_q[$];
   point_type  cur;
   int      fail_cnt = 0;
   int      idle_mode = 0;
   bit      hold_req = 0;
   int      hold_left = 0;

   longint          win_x[4];
   longint          win_y[4];
   longint unsigned knots[3];
   int              seen;
   int              seg_n;

   centripetal_catmull_rom_interpolator_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic longint unsigned sqrt_floor(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint unsigned chord_knot(longint dx, longint dy);
      longint unsigned mx;
      longint unsigned my;
      longint unsigned len;
      mx = (dx < 0) ? -dx : dx;
      my = (dy < 0) ? -dy : dy;
      if (mx > ccr_pkg::DIFF_LIM) mx = ccr_pkg::DIFF_LIM;
      if (my > ccr_pkg::DIFF_LIM) my = ccr_pkg::DIFF_LIM;
      len = sqrt_floor(mx * mx + my * my);
      return sqrt_floor(len << 24);
   endfunction

   function automatic longint ratio(longint num, longint den);
      longint unsigned m;
      longint unsigned q;
      longint w;
      m = (num < 0) ? -num : num;
      q = (m << 16) / longint'(den);
      w = (q > WLIM) ? WLIM : longint'(q);
      return (num < 0) ? -w : w;
   endfunction

   function automatic longint mix(longint p, longint wp, longint q, longint wq);
      longint s;
      longint r;
      s = p * wp + q * wq + 32768;
      r = s >>> 16;
      if (r > ILIM) r = ILIM;
      if (r < -ILIM) r = -ILIM;
      return r;
   endfunction

   function automatic longint spline_axis(input longint p[4], input longint w[10]);
      longint a1, a2, a3, b1, b2;
      a1 = mix(p[0], w[0], p[1], w[1]);
      a2 = mix(p[1], w[2], p[2], w[3]);
      a3 = mix(p[2], w[4], p[3], w[5]);
      b1 = mix(a1, w[6], a2, w[7]);
      b2 = mix(a2, w[8], a3, w[9]);
      return mix(b1, w[2], b2, w[3]);
   endfunction

   function automatic logic [CW-1:0] sat_coord(longint v);
      if (v > CMAX) v = CMAX;
      if (v < CMIN) v = CMIN;
      return v[CW-1:0];
   endfunction

   task automatic push_sample(longint x, longint y, bit cend, bit degen);
      sample_type s;
      s.x = sat_coord(x);
      s.y = sat_coord(y);
      s.run_end = 0;
      s.curve_end = cend;
      s.degen = degen;
      sample_q.push_back(s);
   endtask

   task automatic clear_curve();
      for (int i = 0; i < 4; i++) begin
         win_x[i] = 0;
         win_y[i] = 0;
      end
      for (int i = 0; i < 3; i++) knots[i] = 0;
      seen = 0;
   endtask

   task automatic predict_point(point_type pt);
      longint px, py, k1, k2, k3, t1, t2, t3, t;
      longint w[10];
      longint unsigned kn;
      int prior;
      int cnt;
      px = longint'(signed'(pt.x));
      py = longint'(signed'(pt.y));
      prior = seen;
      kn = 0;
      cnt = 0;
      if (prior >= 1) kn = chord_knot(px - win_x[3], py - win_y[3]);
      for (int i = 0; i < 3; i++) begin
         win_x[i] = win_x[i+1];
         win_y[i] = win_y[i+1];
      end
      win_x[3] = px;
      win_y[3] = py;
      knots[0] = knots[1];
      knots[1] = knots[2];
      knots[2] = kn;
      if (seen < 3) seen++;
      if (seg_n > 0) begin
         if (prior == 3) begin
            k1 = knots[0];
            k2 = knots[1];
            k3 = knots[2];
            for (int j = 0; j < seg_n; j++) begin
               if (k1 == 0 || k2 == 0 || k3 == 0) begin
                  push_sample(win_x[1], win_y[1], 0, 1);
               end else begin
                  t1 = k1;
                  t2 = k1 + k2;
                  t3 = t2 + k3;
                  t = t1 + (longint'(j) * k2) / longint'(seg_n);
                  w[0] = ratio(t1 - t, k1);
                  w[1] = ratio(t, k1);
                  w[2] = ratio(t2 - t, k2);
                  w[3] = ratio(t - t1, k2);
                  w[4] = ratio(t3 - t, k3);
                  w[5] = ratio(t - t2, k3);
                  w[6] = ratio(t2 - t, t2);
                  w[7] = ratio(t, t2);
                  w[8] = ratio(t3 - t, t3 - t1);
                  w[9] = ratio(t - t1, t3 - t1);
                  push_sample(spline_axis(win_x, w), spline_axis(win_y, w), 0, 0);
               end
               cnt++;
            end
         end
         if (pt.fin && prior >= 1) begin
            push_sample(px, py, 1, 0);
            cnt++;
         end
      end
      if (pt.fin) clear_curve();
      if (cnt > 0) sample_q[sample_q.size()-1].run_end = 1;
   endtask

   function automatic bit sender_idles();
      case (idle_mode)
         0: return $urandom_range(0, 99) < 14;
         1: return $urandom_range(0, 99) < 79;
         default: return 0;
      endcase
   endfunction

   function automatic bit receiver_idles();
      case (idle_mode)
         0: return $urandom_range(0, 99) < 79;
         1: return $urandom_range(0, 99) < 14;
         default: return 0;
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tlast <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_point(cur);
         if (!req_tvalid || req_tready) begin
            if (point_q.size() > 0 && !sender_idles()) begin
               cur = point_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {cur.y, cur.x};
               req_tlast <= cur.fin;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      sample_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (sample_q.size() == 0) begin
               $error("unexpected item x=%h y=%h", rsp_tdata[CW-1:0], rsp_tdata[2*CW-1:CW]);
               fail_cnt++;
            end else begin
               e = sample_q.pop_front();
               if (rsp_tdata[CW-1:0] !== e.x) begin
                  $error("out_x expected %h actual %h", e.x, rsp_tdata[CW-1:0]);
                  fail_cnt++;
               end
               if (rsp_tdata[2*CW-1:CW] !== e.y) begin
                  $error("out_y expected %h actual %h", e.y, rsp_tdata[2*CW-1:CW]);
                  fail_cnt++;
               end
               if (rsp_tlast !== e.run_end) begin
                  $error("run_end expected %0d actual %0d", e.run_end, rsp_tlast);
                  fail_cnt++;
               end
               if (rsp_tuser[0] !== e.curve_end) begin
                  $error("curve_end expected %0d actual %0d", e.curve_end, rsp_tuser[0]);
                  fail_cnt++;
               end
               if (rsp_tuser[1] !== e.degen) begin
                  $error("degenerate expected %0d actual %0d", e.degen, rsp_tuser[1]);
                  fail_cnt++;
               end
            end
         end
         if (hold_req && hold_left == 0) begin
            hold_req = 0;
            hold_left <= 3000;
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !receiver_idles();
         end
      end
   end

   task automatic add_point(longint x, longint y, bit fin);
      point_type p;
      p.x = x[CW-1:0];
      p.y = y[CW-1:0];
      p.fin = fin;
      point_q.push_back(p);
   endtask

   task automatic add_curve(int len, ref int added);
      logic [CW-1:0] x, y;
      logic [CW-1:0] step;
      int style;
      x = CW'($urandom);
      y = CW'($urandom);
      for (int i = 0; i < len; i++) begin
         style = $urandom_range(0, 9);
         if (i > 0 && style == 0) begin
            // keep the same point for a zero chord
         end else if (style == 1) begin
            x = CW'($urandom);
            y = CW'($urandom);
         end else begin
            step = CW'((style < 5) ? $urandom_range(0, 255) :
                       (style < 8) ? $urandom_range(0, 65535) : $urandom_range(0, 1 << 21));
            x = x + (($urandom_range(0, 1) != 0) ? step : -step);
            step = CW'((style < 5) ? $urandom_range(0, 255) :
                       (style < 8) ? $urandom_range(0, 65535) : $urandom_range(0, 1 << 21));
            y = y + (($urandom_range(0, 1) != 0) ? step : -step);
         end
         add_point(longint'(signed'(x)), longint'(signed'(y)), i == len - 1);
         added++;
      end
   endtask

   task automatic drain();
      while (point_q.size() > 0 || req_tvalid || sample_q.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic set_segments(int v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v[ccr_pkg::SEG_W-1:0];
      @(posedge clock);
      seg_n = v;
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_phase(int target);
      int added;
      added = 0;
      while (added < target) add_curve($urandom_range(1, 8), added);
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      seg_n = ccr_pkg::SEG_RESET;
      clear_curve();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: short curves, extremes, coincident points
      idle_mode = 0;
      add_point(5, 7, 1);
      add_point(100, -100, 0);
      add_point(300, 200, 1);
      add_point(-50, 0, 0);
      add_point(0, 0, 0);
      add_point(256, 512, 1);
      add_point(CMIN, CMIN, 0);
      add_point(CMAX, CMAX, 0);
      add_point(CMIN, CMAX, 0);
      add_point(CMAX, CMIN, 0);
      add_point(0, 0, 1);
      add_point(100, 100, 0);
      add_point(100, 100, 0);
      add_point(200, 50, 0);
      add_point(300, 80, 1);
      add_point(0, 0, 0);
      add_point(1000, 300, 0);
      add_point(2000, -400, 0);
      add_point(2500, 1200, 0);
      add_point(4000, 900, 1);
      drain();

      set_segments(63);
      add_point(0, 0, 0);
      add_point(512, 256, 0);
      add_point(1536, -256, 0);
      add_point(2048, 1024, 0);
      add_point(3000, 0, 1);
      drain();

      set_segments(0);
      add_point(10, 10, 0);
      add_point(20, 40, 0);
      add_point(60, 30, 0);
      add_point(90, 90, 0);
      add_point(120, 70, 1);
      drain();

      set_segments(1);
      idle_mode = 1;
      random_phase(40);
      drain();

      set_segments($urandom_range(2, 4));
      random_phase(40);
      hold_req = 1;
      drain();

      set_segments(3);
      idle_mode = 2;
      random_phase(40);
      drain();

      repeat (100) @(posedge clock);
      if (fail_cnt == 0 && sample_q.size() == 0) begin
         $display("tb_centripetal_catmull_rom_interpolator_top passed");
      end else begin
         $display("tb_centripetal_catmull_rom_interpolator_top failed");
      end
      $finish;
   end

   initial begin
      #150_000_000;
      $display("tb_centripetal_catmull_rom_interpolator_top failed");
      $finish;
   end

endmodule
